// ===== rtl/core/epd_pkg.sv =====
// shared types, constants and tables of the equirectangular direction core
package epd_pkg;

  localparam int COORD_BITS_DEF    = 13;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int SIZE_W  = 14;  // image size register width
  localparam int DIV_W   = 48;  // dividend width, covers the widest coordinate
  localparam int PHASE_W = 32;  // one turn is 2^32
  localparam int ANG_W   = 33;  // cordic datapath width
  localparam int OUT_W   = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd8192;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd4096;
  localparam logic [ANG_W-1:0]  GAIN_Q30     = 33'd652032874;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic              neg;
    logic [SIZE_W-1:0] rem;
    logic [DIV_W-1:0]  dq;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    div_lane_t lon;
    div_lane_t lat;
  } div_word_t;

  typedef struct packed {
    logic [1:0]              quad;
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_lane_t;

  typedef struct packed {
    logic         valid;
    cordic_lane_t lon;
    cordic_lane_t lat;
  } cordic_word_t;

  // arctangent of 2^-k in phase units
  function automatic logic [PHASE_W-1:0] atan_phase(input int k);
    logic [PHASE_W-1:0] a;
    begin
      unique case (k)
        0:  a = 32'h20000000;
        1:  a = 32'h12E4051D;
        2:  a = 32'h09FB385B;
        3:  a = 32'h051111D4;
        4:  a = 32'h028B0D43;
        5:  a = 32'h0145D7E1;
        6:  a = 32'h00A2F61E;
        7:  a = 32'h00517C55;
        8:  a = 32'h0028BE53;
        9:  a = 32'h00145F2F;
        10: a = 32'h000A2F98;
        11: a = 32'h000517CC;
        12: a = 32'h00028BE6;
        13: a = 32'h000145F3;
        14: a = 32'h0000A2F9;
        15: a = 32'h0000517D;
        16: a = 32'h000028BE;
        17: a = 32'h0000145F;
        18: a = 32'h00000A2F;
        19: a = 32'h00000518;
        20: a = 32'h0000028C;
        21: a = 32'h00000146;
        22: a = 32'h000000A3;
        23: a = 32'h00000051;
        24: a = 32'h00000029;
        25: a = 32'h00000014;
        26: a = 32'h0000000A;
        27: a = 32'h00000005;
        28: a = 32'h00000003;
        29: a = 32'h00000001;
        30: a = 32'h00000001;
        default: a = 32'h00000000;
      endcase
      return a;
    end
  endfunction

endpackage

// ===== rtl/core/epd_div_cell.sv =====
// one restoring division step for both angle lanes
module epd_div_cell
  import epd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] width,
  input  logic [SIZE_W-1:0] height,
  input  div_word_t         din,
  output div_word_t         dout
);

  function automatic div_lane_t div_step(input div_lane_t l, input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    div_lane_t       o;
    begin
      o = l;
      t = {l.rem, l.dq[DIV_W-1]};
      if (t >= {1'b0, d}) begin
        o.rem = SIZE_W'(t - {1'b0, d});
        o.dq  = {l.dq[DIV_W-2:0], 1'b1};
      end else begin
        o.rem = t[SIZE_W-1:0];
        o.dq  = {l.dq[DIV_W-2:0], 1'b0};
      end
      return o;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.lon <= div_step(din.lon, width);
    dout.lat <= div_step(din.lat, height);
  end

endmodule

// ===== rtl/core/epd_cordic_cell.sv =====
// one rotation step of the sine and cosine chain for both angle lanes
module epd_cordic_cell
  import epd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  cordic_word_t din,
  output cordic_word_t dout
);

  localparam logic signed [ANG_W-1:0] ATAN = $signed({1'b0, atan_phase(IDX)});

  function automatic cordic_lane_t rot_step(input cordic_lane_t l);
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;
    cordic_lane_t            o;
    begin
      o  = l;
      dx = l.y >>> IDX;
      dy = l.x >>> IDX;
      if (!l.z[ANG_W-1]) begin
        o.x = l.x - dx;
        o.y = l.y + dy;
        o.z = l.z - ATAN;
      end else begin
        o.x = l.x + dx;
        o.y = l.y - dy;
        o.z = l.z + ATAN;
      end
      return o;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.lon <= rot_step(din.lon);
    dout.lat <= rot_step(din.lat);
  end

endmodule

// ===== rtl/core/equirect_pixel_to_direction_core.sv =====
// top level: panorama pixel position to unit viewing direction
//
// usage
// - a pixel word (pixel_x, pixel_y) is taken at each clock edge with start high
//   and busy low; busy never rises, so one pixel can enter every cycle
// - one direction word (dir_x, dir_y, dir_z, Q1.14 by default) leaves per pixel,
//   shown for one cycle with done high; the receiver cannot stall the block
// - each pixel passes the input register, the chain of 48 long division cells
//   that makes both phases, then one cordic cell per stage, one multiplier stage
//   and the output register
// - throughput is one word per cycle, every cell moves its word on each clock
// - image_width at address 0, image_height at address 4 on the apb port;
//   a size of zero is used as one; write them only while no pixel is in flight
// - reset sets width 8192, height 4096 and empties the pipeline valid bits
module equirect_pixel_to_direction_core
  import epd_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_BITS-1:0]   pixel_x,
  input  logic [COORD_BITS-1:0]   pixel_y,
  output logic                    done,
  output logic signed [OUT_W-1:0] dir_x,
  output logic signed [OUT_W-1:0] dir_y,
  output logic signed [OUT_W-1:0] dir_z,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam int MAG_W = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
  localparam int PROD_W = 2 * ANG_W;
  localparam int SH = 60 - OUT_FRAC_BITS;

  // configuration registers
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // zero size is treated as one
  assign w_eff = (image_width == '0) ? SIZE_W'(1) : image_width;
  assign h_eff = (image_height == '0) ? SIZE_W'(1) : image_height;

  // prepare |2p - size| and sign, then dividend = |num| * 2^sh + size/2
  logic [MAG_W-1:0] two_x;
  logic [MAG_W-1:0] two_y;
  logic [MAG_W-1:0] wm;
  logic [MAG_W-1:0] hm;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic             lt_x;
  logic             lt_y;
  div_word_t        prep;

  always_comb begin
    two_x = MAG_W'({pixel_x, 1'b0});
    two_y = MAG_W'({pixel_y, 1'b0});
    wm    = MAG_W'(w_eff);
    hm    = MAG_W'(h_eff);
    lt_x  = two_x < wm;
    lt_y  = two_y < hm;
    mag_x = lt_x ? wm - two_x : two_x - wm;
    mag_y = lt_y ? hm - two_y : two_y - hm;
    prep.valid   = start;
    prep.lon.neg = lt_x;
    // latitude carries an extra minus sign
    prep.lat.neg = !lt_y;
    prep.lon.rem = '0;
    prep.lat.rem = '0;
    prep.lon.dq  = (DIV_W'(mag_x) << 30) + DIV_W'(w_eff[SIZE_W-1:1]);
    prep.lat.dq  = (DIV_W'(mag_y) << 29) + DIV_W'(h_eff[SIZE_W-1:1]);
  end

  // long division chain, one quotient bit per cell
  div_word_t div_w [DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_w[0].valid <= 1'b0;
    end else begin
      div_w[0].valid <= prep.valid;
    end
    div_w[0].lon <= prep.lon;
    div_w[0].lat <= prep.lat;
  end

  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    epd_div_cell u_div (
      .clk    (clk),
      .rst    (rst),
      .width  (w_eff),
      .height (h_eff),
      .din    (div_w[i]),
      .dout   (div_w[i+1])
    );
  end

  // phase folding into quadrant and residual
  function automatic cordic_lane_t fold(input div_lane_t l);
    logic [PHASE_W-1:0] q;
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] sum;
    logic [PHASE_W-1:0] res;
    cordic_lane_t       o;
    begin
      q      = l.dq[PHASE_W-1:0];
      ph     = l.neg ? PHASE_W'(0) - q : q;
      sum    = ph + 32'h2000_0000;
      o.quad = sum[PHASE_W-1:PHASE_W-2];
      res    = ph - {o.quad, 30'd0};
      o.z    = $signed({res[PHASE_W-1], res});
      o.x    = GAIN_Q30;
      o.y    = '0;
      return o;
    end
  endfunction

  cordic_word_t cw [CORDIC_STAGES+1];

  always_comb begin
    cw[0].valid = div_w[DIV_W].valid;
    cw[0].lon   = fold(div_w[DIV_W].lon);
    cw[0].lat   = fold(div_w[DIV_W].lat);
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    epd_cordic_cell #(.IDX(i)) u_cordic (
      .clk  (clk),
      .rst  (rst),
      .din  (cw[i]),
      .dout (cw[i+1])
    );
  end

  // undo the quadrant fold
  logic signed [ANG_W-1:0] clon, slon, clat, slat;

  always_comb begin
    unique case (cw[CORDIC_STAGES].lon.quad)
      2'd0: begin clon = cw[CORDIC_STAGES].lon.x;  slon = cw[CORDIC_STAGES].lon.y;  end
      2'd1: begin clon = -cw[CORDIC_STAGES].lon.y; slon = cw[CORDIC_STAGES].lon.x;  end
      2'd2: begin clon = -cw[CORDIC_STAGES].lon.x; slon = -cw[CORDIC_STAGES].lon.y; end
      default: begin clon = cw[CORDIC_STAGES].lon.y; slon = -cw[CORDIC_STAGES].lon.x; end
    endcase
    unique case (cw[CORDIC_STAGES].lat.quad)
      2'd0: begin clat = cw[CORDIC_STAGES].lat.x;  slat = cw[CORDIC_STAGES].lat.y;  end
      2'd1: begin clat = -cw[CORDIC_STAGES].lat.y; slat = cw[CORDIC_STAGES].lat.x;  end
      2'd2: begin clat = -cw[CORDIC_STAGES].lat.x; slat = -cw[CORDIC_STAGES].lat.y; end
      default: begin clat = cw[CORDIC_STAGES].lat.y; slat = -cw[CORDIC_STAGES].lat.x; end
    endcase
  end

  // q60 products
  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cw[CORDIC_STAGES].valid;
    end
    prod_x <= -(PROD_W'(clat) * PROD_W'(slon));
    prod_y <= -(PROD_W'(clat) * PROD_W'(clon));
    prod_z <= PROD_W'(slat) <<< 30;
  end

  // round half up, clamp to plus or minus one
  function automatic logic [OUT_W-1:0] to_out(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] lim;
    logic signed [PROD_W-1:0] r;
    begin
      lim = PROD_W'(1) <<< OUT_FRAC_BITS;
      r   = (v + (PROD_W'(1) <<< (SH - 1))) >>> SH;
      if (r > lim) begin
        r = lim;
      end else if (r < -lim) begin
        r = -lim;
      end
      return r[OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_valid;
    end
    dir_x <= to_out(prod_x);
    dir_y <= to_out(prod_y);
    dir_z <= to_out(prod_z);
  end

endmodule
